// ===== hdl/spilling_multi_stack_store_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the multi-stack store
// Short forms for clocked properties that are disabled during reset.
// ---------------------------------------------------------------------------
`ifndef SPILLING_MULTI_STACK_STORE_MACROS_SVH
`define SPILLING_MULTI_STACK_STORE_MACROS_SVH

// Same-cycle implication.
`define SMSS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("multi-stack store assertion failed");

// Next-cycle implication.
`define SMSS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("multi-stack store assertion failed");

`endif

// ===== hdl/smss_pkg.sv =====
// ---------------------------------------------------------------------------
// smss_pkg
// Sizes, codes and helper functions shared by the multi-stack store.
// ---------------------------------------------------------------------------
package smss_pkg;

  localparam int STACK_DEPTH   = 5;
  localparam int NUM_STACKS    = 3;
  localparam int TOTAL_ENTRIES = STACK_DEPTH * NUM_STACKS;

  localparam int FILL_W = $clog2(STACK_DEPTH + 1);
  localparam int STK_W  = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int ADDR_W = (TOTAL_ENTRIES > 1) ? $clog2(TOTAL_ENTRIES) : 1;

  localparam int ID_W     = 32;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 3;
  localparam int USED_W   = 2;
  localparam int IN_W     = 40;
  localparam int OUT_W    = 40;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_CHECK = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE      = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_EMPTY     = 3'd2,
    STAT_FOUND     = 3'd3,
    STAT_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_LAST,
    ST_RESULT
  } state_t;

  // One access to the entry memory.
  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [ID_W-1:0]   wdata;
  } mem_req_t;

  // First memory address of a stack.
  function automatic logic [ADDR_W-1:0] stack_base(input logic [STK_W-1:0] stk);
    logic [ADDR_W+STK_W-1:0] prod;
    prod = (ADDR_W+STK_W)'(stk) * (ADDR_W+STK_W)'(STACK_DEPTH);
    return prod[ADDR_W-1:0];
  endfunction

  // Low two bits of a stack index for the result field.
  function automatic logic [USED_W-1:0] used_field(input logic [STK_W-1:0] stk);
    logic [STK_W+USED_W-1:0] ext;
    ext = {{USED_W{1'b0}}, stk};
    return ext[USED_W-1:0];
  endfunction

endpackage

// ===== hdl/smss_mem.sv =====
// ---------------------------------------------------------------------------
// smss_mem
// Single-port entry memory holding every stack, with registered read data.
// ---------------------------------------------------------------------------
module smss_mem (
  input  logic                         clk,
  input  smss_pkg::mem_req_t           req,
  output logic [smss_pkg::ID_W-1:0]    rdata
);

  logic [smss_pkg::ID_W-1:0] mem [smss_pkg::TOTAL_ENTRIES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
  end

  // Read data holds between reads, so a popped entry stays available.
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.addr];
    end
  end

endmodule

// ===== hdl/spilling_multi_stack_store.sv =====
// ---------------------------------------------------------------------------
// spilling_multi_stack_store
// Several bounded stacks of container IDs in one memory, with spill-over
// push, top-down pop and a search over every stored entry.
// ---------------------------------------------------------------------------
//
//   Channel   Direction  Handshake          Payload
//   s_*       in         s_tvalid/s_tready  command and container ID
//   m_*       out        m_tvalid/m_tready  status, popped ID, stack index
//
// A push or a pop does the memory access and the count update in the
// acceptance cycle; the result state then loads the result register once
// that register is free. A check walks the entry memory one word per
// cycle, stack by stack; the single read port of the entry memory sets
// that pace.
// Reset empties every stack at once; the entry memory itself is not cleared.
// A stalled result sits in the output register; the sequencer waits in its
// result state until the register frees up, and the input is ready only
// when the sequencer is idle.
// ---------------------------------------------------------------------------
module spilling_multi_stack_store (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // [1:0] cmd, [33:2] container_id, [39:34] zero
  input  logic [smss_pkg::IN_W-1:0]     s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [2:0] status, [34:3] popped_id, [36:35] stack_used, [39:37] zero
  output logic [smss_pkg::OUT_W-1:0]    m_tdata
);

  `include "spilling_multi_stack_store_macros.svh"

  // Incoming request fields.
  logic [smss_pkg::CMD_W-1:0] in_cmd;
  logic signed [smss_pkg::ID_W-1:0] in_id;

  assign in_cmd = s_tdata[smss_pkg::CMD_W-1:0];
  assign in_id  = s_tdata[smss_pkg::CMD_W+smss_pkg::ID_W-1:smss_pkg::CMD_W];

  smss_pkg::state_t state, state_next;

  // Per-stack fill counts live in flip-flops; reset empties every stack.
  logic [smss_pkg::FILL_W-1:0] fill [smss_pkg::NUM_STACKS];

  // Result being assembled for the current request.
  smss_pkg::status_t           res_status;
  logic [smss_pkg::USED_W-1:0] res_used;
  logic                        res_pop;

  // Search state.
  logic signed [smss_pkg::ID_W-1:0] key;
  logic [smss_pkg::STK_W-1:0]       scan_s;
  logic [smss_pkg::FILL_W-1:0]      scan_k;
  logic [smss_pkg::ADDR_W-1:0]      scan_base;
  logic                             cmp_valid;
  logic                             hit;

  smss_pkg::mem_req_t          mem_req;
  logic [smss_pkg::ID_W-1:0]   mem_rdata;

  logic accept;
  logic load_out;

  assign accept   = s_tvalid && s_tready;
  assign load_out = (state == smss_pkg::ST_RESULT) && (!m_tvalid || m_tready);

  // Pick the stacks for push and pop: the lowest one with room takes a push,
  // the highest one with entries gives up a pop.
  logic                        push_ok, pop_ok;
  logic [smss_pkg::STK_W-1:0]  push_s, pop_s;
  logic [smss_pkg::FILL_W-1:0] push_fill, pop_fill;

  always_comb begin
    push_ok   = 1'b0;
    push_s    = '0;
    push_fill = '0;
    pop_ok    = 1'b0;
    pop_s     = '0;
    pop_fill  = '0;
    for (int s = smss_pkg::NUM_STACKS - 1; s >= 0; s--) begin
      if (fill[s] < smss_pkg::FILL_W'(smss_pkg::STACK_DEPTH)) begin
        push_ok   = 1'b1;
        push_s    = smss_pkg::STK_W'(s);
        push_fill = fill[s];
      end
    end
    for (int s = 0; s < smss_pkg::NUM_STACKS; s++) begin
      if (fill[s] != '0) begin
        pop_ok   = 1'b1;
        pop_s    = smss_pkg::STK_W'(s);
        pop_fill = fill[s];
      end
    end
  end

  // Search walk: one slot per cycle, moving to the next stack once the
  // current one has no more live entries.
  logic [smss_pkg::FILL_W-1:0] scan_fill;
  logic                        scan_live;
  logic                        stack_end;
  logic                        scan_final;
  logic                        match_now;

  assign scan_fill  = fill[scan_s];
  assign scan_live  = scan_k < scan_fill;
  assign stack_end  = ({1'b0, scan_k} + 1'b1) >= {1'b0, scan_fill};
  assign scan_final = stack_end && (scan_s == smss_pkg::STK_W'(smss_pkg::NUM_STACKS - 1));
  assign match_now  = cmp_valid && (mem_rdata == key);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      smss_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_cmd == smss_pkg::CMD_CHECK) begin
            state_next = smss_pkg::ST_SCAN;
          end else begin
            state_next = smss_pkg::ST_RESULT;
          end
        end
      end
      smss_pkg::ST_SCAN: begin
        if (scan_final) begin
          state_next = smss_pkg::ST_SCAN_LAST;
        end
      end
      smss_pkg::ST_SCAN_LAST: begin
        state_next = smss_pkg::ST_RESULT;
      end
      smss_pkg::ST_RESULT: begin
        if (load_out) begin
          state_next = smss_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = smss_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer: input ready and the memory access.
  always_comb begin
    s_tready      = 1'b0;
    mem_req.we    = 1'b0;
    mem_req.re    = 1'b0;
    mem_req.addr  = '0;
    mem_req.wdata = in_id;
    case (state)
      smss_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          case (in_cmd)
            smss_pkg::CMD_PUSH: begin
              mem_req.we   = push_ok;
              mem_req.addr = smss_pkg::stack_base(push_s)
                             + smss_pkg::ADDR_W'(push_fill);
            end
            smss_pkg::CMD_POP: begin
              mem_req.re   = pop_ok;
              mem_req.addr = smss_pkg::stack_base(pop_s)
                             + smss_pkg::ADDR_W'(pop_fill - 1'b1);
            end
            default: begin
              mem_req.we = 1'b0;
            end
          endcase
        end
      end
      smss_pkg::ST_SCAN: begin
        mem_req.re   = scan_live;
        mem_req.addr = scan_base + smss_pkg::ADDR_W'(scan_k);
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  smss_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= smss_pkg::ST_IDLE;
      m_tvalid <= 1'b0;
      for (int s = 0; s < smss_pkg::NUM_STACKS; s++) begin
        fill[s] <= '0;
      end
    end else begin
      state <= state_next;
      if (accept && (in_cmd == smss_pkg::CMD_PUSH) && push_ok) begin
        fill[push_s] <= push_fill + 1'b1;
      end
      if (accept && (in_cmd == smss_pkg::CMD_POP) && pop_ok) begin
        fill[pop_s] <= pop_fill - 1'b1;
      end
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (load_out) begin
        m_tvalid <= 1'b1;
      end
    end
  end

  // Result and search datapath.
  always_ff @(posedge clk) begin
    case (state)
      smss_pkg::ST_IDLE: begin
        key       <= in_id;
        scan_s    <= '0;
        scan_k    <= '0;
        scan_base <= '0;
        cmp_valid <= 1'b0;
        hit       <= 1'b0;
        res_pop   <= 1'b0;
        res_used  <= '0;
        res_status <= smss_pkg::STAT_DONE;
        case (in_cmd)
          smss_pkg::CMD_PUSH: begin
            if (push_ok) begin
              res_used <= smss_pkg::used_field(push_s);
            end else begin
              res_status <= smss_pkg::STAT_FULL;
            end
          end
          smss_pkg::CMD_POP: begin
            if (pop_ok) begin
              res_used <= smss_pkg::used_field(pop_s);
              res_pop  <= 1'b1;
            end else begin
              res_status <= smss_pkg::STAT_EMPTY;
            end
          end
          default: begin
            res_pop <= 1'b0;
          end
        endcase
      end
      smss_pkg::ST_SCAN: begin
        cmp_valid <= scan_live;
        if (match_now) begin
          hit <= 1'b1;
        end
        if (stack_end) begin
          scan_s    <= scan_s + 1'b1;
          scan_k    <= '0;
          scan_base <= scan_base + smss_pkg::ADDR_W'(smss_pkg::STACK_DEPTH);
        end else begin
          scan_k <= scan_k + 1'b1;
        end
      end
      smss_pkg::ST_SCAN_LAST: begin
        cmp_valid  <= 1'b0;
        res_status <= (hit || match_now) ? smss_pkg::STAT_FOUND
                                         : smss_pkg::STAT_NOT_FOUND;
      end
      default: begin
        cmp_valid <= 1'b0;
      end
    endcase
    if (load_out) begin
      m_tdata <= {{(smss_pkg::OUT_W - smss_pkg::STATUS_W - smss_pkg::ID_W
                    - smss_pkg::USED_W){1'b0}},
                  res_used,
                  (res_pop ? mem_rdata : {smss_pkg::ID_W{1'b0}}),
                  res_status};
    end
  end

  // The block works on one request at a time.
  `SMSS_ASSERT_NXT(a_one_at_a_time, accept, !s_tready)
  // A result in flight always carries a defined status code.
  `SMSS_ASSERT_IMP(a_status_code, m_tvalid,
    m_tdata[smss_pkg::STATUS_W-1:0] <= smss_pkg::STAT_NOT_FOUND)
  // Only a completed push or pop names a stack or returns an ID.
  `SMSS_ASSERT_IMP(a_fields_zero,
    m_tvalid && (m_tdata[smss_pkg::STATUS_W-1:0] != smss_pkg::STAT_DONE),
    m_tdata[smss_pkg::OUT_W-1:smss_pkg::STATUS_W] == '0)
  // The search never walks past the last stack.
  `SMSS_ASSERT_IMP(a_scan_range, state == smss_pkg::ST_SCAN,
    scan_s <= smss_pkg::STK_W'(smss_pkg::NUM_STACKS - 1))

endmodule
